FILE: hdl/pf_pkg.sv
// ----------------------------------------------------------------------------
// Prime factoriser package
// Sequencer state encoding, divider status bundle and fixed trial constants.
// ----------------------------------------------------------------------------
package pf_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } pf_state_t;

    // Status from the shared divider back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } pf_div_stat_t;

    // First trial divisor, and the stride over odd candidates after it
    localparam int unsigned FIRST_DIVISOR = 2;
    localparam int unsigned ODD_STEP      = 2;

endpackage

FILE: hdl/pf_if.sv
// ----------------------------------------------------------------------------
// Prime factoriser stream interfaces
// Valid/ready channels for the input number and for the factor results.
// ----------------------------------------------------------------------------
interface pf_in_if #(
    parameter int WIDTH = 16
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface pf_out_if #(
    parameter int WIDTH = 16
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] factor;
    logic             input_is_prime;
    logic             last;

    modport source (output valid, output factor, output input_is_prime, output last,
                    input ready);
    modport sink   (input valid, input factor, input input_is_prime, input last,
                    output ready);
endinterface

FILE: hdl/prime_factorizer_top.sv
// Inputs 0 and 1 skip the trial loop and give their single word.
// Other inputs run about (sqrt(n)/2 + k + 1) divisions on the bit-serial
// divider (k = number of prime factors). Factors then leave one word a
// cycle while the receiver is ready. One number is handled at a time; the
// next is taken once the last word is loaded. Reset is asynchronous and
// clears control state only.
// ----------------------------------------------------------------------------
// Prime factoriser top level
// Trial division by 2 and odd candidates on a shared divider; factors are
// stacked and returned largest first with a prime flag and a last mark.
// ----------------------------------------------------------------------------
module prime_factorizer_top
    import pf_pkg::*;
#(
    parameter int WIDTH       = 16,
    parameter int MAX_FACTORS = 16
) (
    input logic         clk,
    input logic         rst_n,
    pf_in_if.sink       number_ch,
    pf_out_if.source    factor_ch
);

    localparam int SP_W  = $clog2(WIDTH + 1);
    localparam int IDX_W = $clog2(WIDTH);
    localparam int EC_W  = $clog2(MAX_FACTORS + 1);

    pf_state_t        state_reg, state_next;
    logic [WIDTH-1:0] v_reg, v_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [EC_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic             prime_reg, prime_next;
    logic [WIDTH-1:0] stack_reg [WIDTH];

    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] factor_reg, factor_next;
    logic             out_prime_reg, out_prime_next;
    logic             last_reg, last_next;

    logic             div_start;
    logic [WIDTH-1:0] div_q;
    logic [WIDTH-1:0] div_r;
    pf_div_stat_t     div_stat;

    logic             accept;
    logic             trial_end;
    logic             v_gt1;
    logic             pop;
    logic             pop_last;
    logic             push_en;
    logic [WIDTH-1:0] push_val;

    // Shared divider: v / d each trial
    pf_divider #(
        .WIDTH (WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (v_reg),
        .divisor   (d_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    // Trial loop ends once d exceeds v / d, i.e. d * d > v
    assign accept    = number_ch.valid && number_ch.ready;
    assign trial_end = d_reg > div_q;
    assign v_gt1     = v_reg > WIDTH'(1);

    // Pop when the output register is free or being drained
    assign pop      = (state_reg == ST_EMIT) && (!out_valid_reg || factor_ch.ready);
    assign pop_last = (sp_reg == SP_W'(1)) || (emit_cnt_reg == EC_W'(MAX_FACTORS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (number_ch.valid)
                    state_next = (number_ch.number <= WIDTH'(1)) ? ST_EMIT : ST_START;
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_stat.done)
                    state_next = trial_end ? ST_EMIT : ST_START;
            end
            ST_EMIT:
            begin
                if (pop && pop_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State-decoded outputs
    always_comb
    begin
        number_ch.ready = (state_reg == ST_IDLE);
        div_start       = (state_reg == ST_START);
    end

    // Datapath: operand, divisor, factor stack and output word
    always_comb
    begin
        v_next         = v_reg;
        d_next         = d_reg;
        sp_next        = sp_reg;
        emit_cnt_next  = emit_cnt_reg;
        prime_next     = prime_reg;
        push_en        = 1'b0;
        push_val       = v_reg;
        factor_next    = factor_reg;
        out_prime_next = out_prime_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !factor_ch.ready;

        if (accept)
        begin
            v_next        = number_ch.number;
            d_next        = WIDTH'(FIRST_DIVISOR);
            sp_next       = '0;
            emit_cnt_next = '0;
            // zero and one skip the trial loop: stack the value itself
            if (number_ch.number <= WIDTH'(1))
            begin
                push_en    = 1'b1;
                push_val   = number_ch.number;
                sp_next    = SP_W'(1);
                prime_next = number_ch.number[0];
            end
        end
        else if ((state_reg == ST_WAIT) && div_stat.done)
        begin
            if (trial_end)
            begin
                // what is left over is prime
                push_en    = v_gt1;
                push_val   = v_reg;
                sp_next    = sp_reg + SP_W'(v_gt1);
                prime_next = ((sp_reg == '0) && v_gt1) || ((sp_reg == SP_W'(1)) && !v_gt1);
            end
            else if (div_r == '0)
            begin
                push_en  = 1'b1;
                push_val = d_reg;
                sp_next  = sp_reg + 1'b1;
                v_next   = div_q;
            end
            else
            begin
                d_next = (d_reg == WIDTH'(FIRST_DIVISOR)) ? WIDTH'(FIRST_DIVISOR + 1)
                                                          : d_reg + WIDTH'(ODD_STEP);
            end
        end

        if (pop)
        begin
            // stack is left empty after the final word, also when the limit cuts it short
            sp_next        = pop_last ? '0 : sp_reg - 1'b1;
            emit_cnt_next  = emit_cnt_reg + 1'b1;
            factor_next    = stack_reg[IDX_W'(sp_reg - 1'b1)];
            out_prime_next = prime_reg;
            last_next      = pop_last;
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        d_reg         <= d_next;
        prime_reg     <= prime_next;
        factor_reg    <= factor_next;
        out_prime_reg <= out_prime_next;
        last_reg      <= last_next;
    end

    // Factor stack, ascending from the bottom
    always_ff @(posedge clk)
    begin
        if (push_en)
            stack_reg[sp_reg[IDX_W-1:0]] <= push_val;
    end

    assign factor_ch.valid          = out_valid_reg;
    assign factor_ch.factor         = factor_reg;
    assign factor_ch.input_is_prime = out_prime_reg;
    assign factor_ch.last           = last_reg;

    // Stack depth is bounded by the operand width
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(WIDTH))
        else $error("factor stack overflow");

    // Never more words than the factor limit for one number
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= EC_W'(MAX_FACTORS))
        else $error("too many factors emitted");

    // Divider results only arrive while the sequencer waits for them
    a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_WAIT))
        else $error("divider result outside wait state");

    // Final word is presented marked and the block is free again
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_last) |=> (number_ch.ready && factor_ch.valid && factor_ch.last))
        else $error("final word not marked");

    // Only one number in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !number_ch.ready)
        else $error("second number taken while busy");

endmodule

FILE: hdl/pf_divider.sv
// ----------------------------------------------------------------------------
// Prime factoriser divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pf_divider
    import pf_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder,
    output pf_div_stat_t     stat
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = ~diff[WIDTH];

    // Iteration control and datapath
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result registers, no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // A started division is under way on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");

    // Completion is a single-cycle strobe after the run has ended
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg ##1 !done_reg)
        else $error("divider done strobe malformed");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Prime factoriser testbench
// Feeds numbers over the input channel and checks every factor word against
// a trial-division predictor kept in a small scoreboard. Directed corner
// numbers first, then a random mix of plain, smooth and prime-power numbers,
// with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH       = 16;
    localparam int MAX_FACTORS = 16;
    localparam int N_RANDOM    = 117;

    // One factor word as it leaves the block
    typedef struct {
        logic [WIDTH-1:0] factor;
        logic             input_is_prime;
        logic             last;
    } factor_word_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the factor words of each accepted number
    // ------------------------------------------------------------------------
    class factor_board;
        factor_word_t factor_q[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Append one expected word at the tail
        function void queue_word(input factor_word_t w);
            factor_q = {factor_q, w};
        endfunction

        // Trial division, factors stacked ascending then queued largest first
        function void note_number(input logic [WIDTH-1:0] n);
            int unsigned      v;
            int unsigned      d;
            logic [WIDTH-1:0] asc[$];
            logic             is_prime;
            int               emit;
            factor_word_t     w;
            if (n == 0)
            begin
                w.factor = '0;
                w.input_is_prime = 1'b0;
                w.last = 1'b1;
                queue_word(w);
            end
            else if (n <= 3)
            begin
                // 1, 2 and 3 stand as their own single factor
                w.factor = n;
                w.input_is_prime = 1'b1;
                w.last = 1'b1;
                queue_word(w);
            end
            else
            begin
                v = n;
                d = 2;
                while (d * d <= v)
                begin
                    while (v % d == 0)
                    begin
                        asc = {asc, d[WIDTH-1:0]};
                        v = v / d;
                    end
                    d++;
                end
                if (v > 1)
                    asc = {asc, v[WIDTH-1:0]};
                is_prime = (asc.size() == 1);
                emit = (asc.size() < MAX_FACTORS) ? asc.size() : MAX_FACTORS;
                for (int k = 0; k < emit; k++)
                begin
                    w.factor = asc[asc.size() - 1 - k];
                    w.input_is_prime = is_prime;
                    w.last = (k == emit - 1);
                    queue_word(w);
                end
            end
        endfunction

        // Compare one accepted word with the oldest prediction
        task check_word(input logic [WIDTH-1:0] f, input logic p, input logic l);
            factor_word_t w;
            if (factor_q.size() == 0)
            begin
                report($sformatf("unexpected word factor=%0d prime=%b last=%b", f, p, l));
                return;
            end
            w = factor_q.pop_front();
            if (f !== w.factor)
                report($sformatf("factor %0d, wanted %0d", f, w.factor));
            if (p !== w.input_is_prime)
                report($sformatf("input_is_prime %b, wanted %b (factor %0d)",
                                 p, w.input_is_prime, w.factor));
            if (l !== w.last)
                report($sformatf("last %b, wanted %b (factor %0d)", l, w.last, w.factor));
        endtask
    endclass

    logic clk;
    logic rst_n;

    pf_in_if  #(.WIDTH(WIDTH)) number_ch ();
    pf_out_if #(.WIDTH(WIDTH)) factor_ch ();

    factor_board board;

    prime_factorizer_top #(
        .WIDTH       (WIDTH),
        .MAX_FACTORS (MAX_FACTORS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .number_ch (number_ch),
        .factor_ch (factor_ch)
    );

    // Clock
    always #5 clk = ~clk;

    // Known values on every input from time zero
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        number_ch.valid = 1'b0;
        number_ch.number = '0;
        factor_ch.ready = 1'b0;
    end

    // Send one number after a gap; returns once the word is accepted
    task send_number(input logic [WIDTH-1:0] n, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            number_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        number_ch.valid <= 1'b1;
        number_ch.number <= n;
        do
            @(posedge clk);
        while (!number_ch.ready);
        board.note_number(n);
    endtask

    // Sender gap: no gaps in every third block of 25 numbers
    function automatic int sender_gap(input int idx);
        if ((idx / 25) % 3 == 2)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Stimulus
    initial
    begin
        logic [WIDTH-1:0] directed[$];
        int unsigned      p;
        int unsigned      acc;
        int unsigned      sel;
        int unsigned      primes[6];
        int               idx;

        primes = '{2, 3, 5, 7, 11, 13};
        board = new();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Corner numbers: zero, one, small primes, all ones, largest prime,
        // highest power of two, alternating bits, prime squares, smooth numbers
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd8, 16'd9,
                     16'd12, 16'd65535, 16'd65521, 16'd32768, 16'd65534, 16'h5555,
                     16'hAAAA, 16'd65025, 16'd49729, 16'd59049, 16'd30030,
                     16'd64009, 16'd65533, 16'd32767};
        idx = 0;
        foreach (directed[i])
        begin
            send_number(directed[i], sender_gap(idx));
            idx++;
        end

        // Random mix of number shapes
        for (int i = 0; i < N_RANDOM; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                acc = $urandom_range(0, 65535);
            else if (sel < 6)
                acc = $urandom_range(0, 64);
            else if (sel < 8)
            begin
                // smooth number: product of small primes
                acc = 1;
                do
                begin
                    p = primes[$urandom_range(0, 5)];
                    if (acc * p <= 65535)
                        acc = acc * p;
                end
                while ($urandom_range(0, 7) != 0 && acc * 2 <= 65535);
            end
            else if (sel == 8)
            begin
                // power of one prime
                p = primes[$urandom_range(0, 5)];
                acc = p;
                while (acc * p <= 65535 && $urandom_range(0, 4) != 0)
                    acc = acc * p;
            end
            else
                acc = $urandom_range(32768, 65535) | 1;
            send_number(acc[WIDTH-1:0], sender_gap(idx));
            idx++;
        end

        @(negedge clk);
        number_ch.valid <= 1'b0;

        // Drain, then a short settle for stray words
        while (board.factor_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: random stall before each word, stall-free stretches too
    initial
    begin
        int stall;
        int words;
        words = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ((words / 40) % 3 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 17);
            @(negedge clk);
            if (stall > 0)
            begin
                factor_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            factor_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!factor_ch.valid);
            board.check_word(factor_ch.factor, factor_ch.input_is_prime, factor_ch.last);
            words++;
        end
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pf_pkg.sv
hdl/pf_if.sv
hdl/pf_divider.sv
hdl/prime_factorizer_top.sv
tb/tb_top.sv
